// ===== hw/rtl/mvam_pkg.sv =====
// mvam_pkg: shared types and constants of the multi-voice audio mixer
// used by the controller, the datapath and the top level; depends on nothing

package mvam_pkg;

  // default sizes of the voice set, clip table and sample store
  localparam int DEF_VOICE_COUNT  = 32;
  localparam int DEF_CLIP_COUNT   = 64;
  localparam int DEF_SAMPLE_DEPTH = 65536;

  // stream payload widths in bits; the two data widths are whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;

  // unity gain in Q1.15 and the reset value of the master gain
  localparam logic [15:0] UNITY_GAIN = 16'h8000;

  // register stages between a voice issue and the accumulator update
  localparam int PIPE_LAT = 6;

  // operation codes carried in tuser
  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_DEFINE = 3'd1,
    MODE_PLAY   = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_ALL    = 3'd4,
    MODE_TICK   = 3'd5
  } mode_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;    // input transfer: latch the item, do the table writes
    logic issue;    // a voice enters the pipeline this cycle
    logic load_out; // copy the finished result into the output register
  } cmd_t;

endpackage

// ===== hw/rtl/mvam_ctrl.sv =====
// mvam_ctrl: sequencer of the mixer, walks the voices and hands out the result
// depends on mvam_pkg (cmd_t, PIPE_LAT)

module mvam_ctrl #(
  parameter int VOICE_COUNT = mvam_pkg::DEF_VOICE_COUNT,
  parameter int VIDX_W      = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output mvam_pkg::cmd_t     cmd,
  output logic [VIDX_W-1:0]  vidx
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);
  localparam logic [2:0]        LAST_DRAIN = 3'(mvam_pkg::PIPE_LAT - 1);

  state_t     state;
  logic       rdy;
  logic       issue;
  logic       out_vld;
  logic [2:0] dcnt;
  logic       accept;
  logic       load;

  // handshake decode
  assign accept   = s_tvalid && rdy;
  assign load     = (state == ST_FINISH) && (!out_vld || m_tready);
  assign s_tready = rdy;
  assign m_tvalid = out_vld;

  assign cmd.start    = accept;
  assign cmd.issue    = issue;
  assign cmd.load_out = load;

  // state machine; s_tready, m_tvalid, issue and vidx are registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rdy     <= 1'b0;
      issue   <= 1'b0;
      out_vld <= 1'b0;
      vidx    <= '0;
      dcnt    <= '0;
    end else begin
      // output register empties on a transfer unless refilled
      if (load) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_WALK;
            rdy   <= 1'b0;
            issue <= 1'b1;
            vidx  <= '0;
          end else begin
            rdy <= 1'b1;
          end
        end
        ST_WALK: begin
          if (vidx == LAST_VOICE) begin
            state <= ST_DRAIN;
            issue <= 1'b0;
            dcnt  <= '0;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        ST_DRAIN: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == LAST_DRAIN) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load) begin
            state <= ST_IDLE;
            rdy   <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/mvam_datapath.sv =====
// mvam_datapath: sample store, clip table, voice state and the mixing pipeline
// depends on mvam_pkg (mode_t, cmd_t, UNITY_GAIN)

module mvam_datapath #(
  parameter int VOICE_COUNT  = mvam_pkg::DEF_VOICE_COUNT,
  parameter int CLIP_COUNT   = mvam_pkg::DEF_CLIP_COUNT,
  parameter int SAMPLE_DEPTH = mvam_pkg::DEF_SAMPLE_DEPTH,
  parameter int VIDX_W       = 5
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mvam_pkg::cmd_t                      cmd,
  input  logic [VIDX_W-1:0]                   vidx,
  input  logic                                cfg_wr_en,
  input  logic [15:0]                         cfg_wr_data,
  input  logic [mvam_pkg::IN_USER_W-1:0]      in_user,
  input  logic [mvam_pkg::IN_DATA_W-1:0]      in_data,
  output logic [mvam_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int CLIP_AW = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
  localparam int SA_W    = $clog2(SAMPLE_DEPTH);
  // reciprocal for the address reduction modulo the store depth
  localparam logic [10:0] RECIP   = 11'((1 << 18) / SAMPLE_DEPTH);
  localparam logic [20:0] DEPTH_C = 21'(SAMPLE_DEPTH);
  localparam logic [8:0]  CLIPS_C = 9'(CLIP_COUNT);

  // item fields
  logic [15:0]        f_addr;
  logic [5:0]         f_cid;
  logic [15:0]        f_left;
  logic [15:0]        f_right;
  logic [16:0]        f_len;
  logic [15:0]        f_vol;
  logic               f_loop;
  mvam_pkg::mode_t    f_mode;

  assign f_addr  = in_data[15:0];
  assign f_cid   = in_data[21:16];
  assign f_left  = in_data[37:22];
  assign f_right = in_data[53:38];
  assign f_len   = in_data[70:54];
  assign f_vol   = in_data[86:71];
  assign f_loop  = in_data[87];
  assign f_mode  = mvam_pkg::mode_t'(in_user);

  // latched item
  mvam_pkg::mode_t mode;
  logic [5:0]      cid;
  logic            cid_ok;
  logic [15:0]     vol;
  logic            loop_en;
  logic [15:0]     master;

  // master gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      master <= mvam_pkg::UNITY_GAIN;
    end else if (cfg_wr_en) begin
      master <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode    <= f_mode;
      cid     <= f_cid;
      cid_ok  <= 9'(f_cid) < CLIPS_C;
      vol     <= (f_vol > mvam_pkg::UNITY_GAIN) ? mvam_pkg::UNITY_GAIN : f_vol;
      loop_en <= f_loop;
    end
  end

  // sample store, left in the low half
  logic [31:0]     smem [SAMPLE_DEPTH];
  logic [SA_W-1:0] s_raddr;
  logic [31:0]     s_rdata;

  always_ff @(posedge clk) begin
    if (cmd.start && f_mode == mvam_pkg::MODE_WRITE && 21'(f_addr) < DEPTH_C) begin
      smem[SA_W'(f_addr)] <= {f_right, f_left};
    end
    s_rdata <= smem[s_raddr];
  end

  // clip table, start in the low bits, length above
  logic [32:0]        cmem [CLIP_COUNT];
  logic [CLIP_COUNT-1:0] cvld;
  logic [CLIP_AW-1:0] c_raddr;
  logic [32:0]        c_rdata;
  logic               c_rvld;
  logic               def_wr;

  assign def_wr = cmd.start && f_mode == mvam_pkg::MODE_DEFINE && 9'(f_cid) < CLIPS_C;

  always_ff @(posedge clk) begin
    if (def_wr) begin
      cmem[CLIP_AW'(f_cid)] <= {f_len, f_addr};
    end
    c_rdata <= cmem[c_raddr];
  end

  // written marks, an unwritten entry reads as an invalid clip
  always_ff @(posedge clk) begin
    if (rst) begin
      cvld   <= '0;
      c_rvld <= 1'b0;
    end else begin
      if (def_wr) begin
        cvld[CLIP_AW'(f_cid)] <= 1'b1;
      end
      c_rvld <= cvld[c_raddr];
    end
  end

  // voice state
  logic [VOICE_COUNT-1:0] v_act;
  logic [5:0]             v_clip [VOICE_COUNT];
  logic [16:0]            v_pos  [VOICE_COUNT];
  logic [15:0]            v_gain [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] v_loop;

  // issue stage: clip lookup for the voice or for the item's clip
  assign c_raddr = (mode == mvam_pkg::MODE_TICK) ? CLIP_AW'(v_clip[vidx]) : CLIP_AW'(cid);

  logic              s1_vld;
  logic [VIDX_W-1:0] s1_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= cmd.issue;
    end
    s1_v <= vidx;
  end

  // decide stage: voice update and status
  logic        d_act;
  logic [5:0]  d_clip;
  logic [16:0] d_pos;
  logic        d_loop;
  logic [15:0] c_start;
  logic [16:0] c_len;
  logic        new_act;
  logic [16:0] new_pos;
  logic [16:0] pos_eff;
  logic        take;
  logic        contrib;
  logic [5:0]  eff_clip;
  logic        taken;
  logic        started;
  logic        playing;
  logic [5:0]  count;

  assign d_act   = v_act[s1_v];
  assign d_clip  = v_clip[s1_v];
  assign d_pos   = v_pos[s1_v];
  assign d_loop  = v_loop[s1_v];
  assign c_start = c_rvld ? c_rdata[15:0]  : 16'd0;
  assign c_len   = c_rvld ? c_rdata[32:16] : 17'd0;

  always_comb begin
    new_act = d_act;
    new_pos = d_pos;
    pos_eff = d_pos;
    take    = 1'b0;
    contrib = 1'b0;
    unique case (mode)
      mvam_pkg::MODE_PLAY: begin
        if (cid_ok && c_len != 17'd0 && !taken && !d_act) begin
          take    = 1'b1;
          new_act = 1'b1;
          new_pos = 17'd0;
        end
      end
      mvam_pkg::MODE_STOP: begin
        if (d_clip == cid) begin
          new_act = 1'b0;
          new_pos = 17'd0;
        end
      end
      mvam_pkg::MODE_ALL: begin
        new_act = 1'b0;
        new_pos = 17'd0;
      end
      mvam_pkg::MODE_TICK: begin
        if (d_act && c_len != 17'd0) begin
          if (d_pos >= c_len && !d_loop) begin
            new_act = 1'b0;
          end else begin
            pos_eff = (d_pos >= c_len) ? 17'd0 : d_pos;
            contrib = 1'b1;
            new_pos = pos_eff + 17'd1;
          end
        end
      end
      default: begin
      end
    endcase
    eff_clip = take ? cid : d_clip;
  end

  // voice write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      v_act <= '0;
    end else if (s1_vld) begin
      v_act[s1_v] <= new_act;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      v_pos[s1_v] <= new_pos;
      if (take) begin
        v_clip[s1_v] <= cid;
        v_gain[s1_v] <= vol;
        v_loop[s1_v] <= loop_en;
      end
    end
  end

  // status gathered over the walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      taken   <= 1'b0;
      started <= 1'b0;
      playing <= 1'b0;
      count   <= '0;
    end else if (s1_vld) begin
      if (take) begin
        taken   <= 1'b1;
        started <= 1'b1;
      end
      count   <= count + 6'(new_act);
      playing <= playing || (new_act && eff_clip == cid);
    end
  end

  // frame index and combined gain
  logic        s2_vld;
  logic [17:0] s2_sum;
  logic [30:0] s2_gprod;
  logic [15:0] m_clamp;

  assign m_clamp = (master > mvam_pkg::UNITY_GAIN) ? mvam_pkg::UNITY_GAIN : master;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld && contrib;
    end
    s2_sum   <= 18'(c_start) + 18'(pos_eff);
    s2_gprod <= 31'(v_gain[s1_v]) * 31'(m_clamp);
  end

  // quotient estimate for the modulo
  logic        s3_vld;
  logic [17:0] s3_sum;
  logic [10:0] s3_q;
  logic [15:0] s3_g;
  logic [28:0] q_prod;

  assign q_prod = 29'(s2_sum) * 29'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_sum <= s2_sum;
    s3_q   <= q_prod[28:18];
    s3_g   <= s2_gprod[30:15];
  end

  // remainder, off by at most one depth
  logic        s4_vld;
  logic [17:0] s4_r;
  logic [15:0] s4_g;
  logic [31:0] qd;
  logic [20:0] r_fix;

  assign qd = 32'(s3_q) * 32'(DEPTH_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    s4_r <= s3_sum - qd[17:0];
    s4_g <= s3_g;
  end

  // final correction and sample read
  assign r_fix   = (21'(s4_r) >= DEPTH_C) ? 21'(s4_r) - DEPTH_C : 21'(s4_r);
  assign s_raddr = SA_W'(r_fix);

  logic        s5_vld;
  logic [15:0] s5_g;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
    s5_g <= s4_g;
  end

  // per-channel products
  logic               s6_vld;
  logic signed [32:0] s6_pl;
  logic signed [32:0] s6_pr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
    s6_pl <= 33'($signed(s_rdata[15:0])) * 33'($signed({1'b0, s5_g}));
    s6_pr <= 33'($signed(s_rdata[31:16])) * 33'($signed({1'b0, s5_g}));
  end

  // scale and saturating accumulate
  logic signed [15:0] acc_l;
  logic signed [15:0] acc_r;
  logic signed [18:0] sum_l;
  logic signed [18:0] sum_r;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign sum_l = 19'(acc_l) + 19'(s6_pl >>> 15);
  assign sum_r = 19'(acc_r) + 19'(s6_pr >>> 15);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (s6_vld) begin
      acc_l <= sat16(sum_l);
      acc_r <= sat16(sum_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {count, playing, started, acc_r, acc_l};
    end
  end

endmodule

// ===== hw/rtl/multi_voice_audio_mixer.sv =====
// multi_voice_audio_mixer: top level of the sample-playback mixer
// depends on mvam_pkg, mvam_ctrl and mvam_datapath
//
// Usage: one operation per input transfer on the s_ group, tuser holding the
// mode (write sample, define clip, play, stop clip, stop all, tick) and tdata
// its operands. Every operation returns exactly one m_ transfer with the mixed
// stereo frame (zero except on tick), the play flag, the clip playing flag and
// the count of active voices.
// Timing: every item walks all voices, one voice a cycle through a six-stage
// pipeline (clip lookup, index, modulo, sample read, scale, accumulate); the
// pipeline then drains and the result is loaded before s_tready rises again,
// so the block takes one item at a time. The result sits in an output
// register; while the receiver stalls, the block finishes the current item and
// then holds until the output register frees. The user must write the master
// gain (cfg_wr_en, cfg_wr_data) only while idle; the block does not check it.
// Reset: rst is synchronous; voices go inactive, clips invalid, master gain to
// unity. Sample memory holds no reset value and needs no clearing pass.

module multi_voice_audio_mixer #(
  parameter int VOICE_COUNT  = mvam_pkg::DEF_VOICE_COUNT,
  parameter int CLIP_COUNT   = mvam_pkg::DEF_CLIP_COUNT,
  parameter int SAMPLE_DEPTH = mvam_pkg::DEF_SAMPLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [15:0]                       cfg_wr_data,  // master_volume
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // sample_address, clip_id, left_sample, right_sample, clip_length,
  // play_volume, loop_enable
  input  logic [mvam_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [mvam_pkg::IN_USER_W-1:0]    s_tuser,      // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // left_out, right_out, voice_started, clip_playing, active_voices
  output logic [mvam_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  mvam_pkg::cmd_t    cmd;
  logic [VIDX_W-1:0] vidx;

  // sequencer
  mvam_ctrl #(
    .VOICE_COUNT (VOICE_COUNT),
    .VIDX_W      (VIDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .vidx     (vidx)
  );

  // storage and mixing pipeline
  mvam_datapath #(
    .VOICE_COUNT  (VOICE_COUNT),
    .CLIP_COUNT   (CLIP_COUNT),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .VIDX_W       (VIDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .vidx        (vidx),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_user     (s_tuser),
    .in_data     (s_tdata),
    .out_data    (m_tdata)
  );

endmodule

// ===== hw/rtl/mvam_checker.sv =====
// mvam_checker: port-level assertions for the mixer, bound to the top level
// depends on mvam_pkg (payload widths)

module mvam_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mvam_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: input closes after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a transfer");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // a started voice plays the requested clip
  a_started: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> m_tdata[33])
    else $error("voice started but clip not playing");

endmodule

bind multi_voice_audio_mixer mvam_checker u_mvam_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/tb_multi_voice_audio_mixer.sv =====
// tb_multi_voice_audio_mixer: self-checking testbench of the sample-playback mixer
// drives directed and random operations, predicts every result; needs mvam_pkg and the rtl

module tb_multi_voice_audio_mixer;

  timeunit 1ns;
  timeprecision 1ps;

  // the two mode codes the block treats as no operation
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  // sample region that every playable clip stays inside, wrapping past the top
  localparam logic [15:0] SAFE_BASE = 16'hFFC0;
  localparam int          SAFE_SPAN = 192;
  // clips from this id up get arbitrary definitions and are never played
  localparam int          WILD_CLIP = 48;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] addr;
    logic [5:0]  cid;
    logic [15:0] lsmp;
    logic [15:0] rsmp;
    logic [16:0] len;
    logic [15:0] vol;
    logic        lp;
  } mix_item_t;

  // same layout as m_tdata, lowest field last
  typedef struct packed {
    logic [5:0]  count;
    logic        playing;
    logic        started;
    logic [15:0] right;
    logic [15:0] left;
  } mix_res_t;

  typedef struct {
    mix_item_t it;
    bit        typed;
    mix_res_t  want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [15:0]                     cfg_wr_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mvam_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [mvam_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mvam_pkg::OUT_DATA_W-1:0] m_tdata;

  // predictor copy of the mixer state
  logic [31:0] pm_samples [int];
  logic [15:0] pm_clip_start [64];
  logic [16:0] pm_clip_len [64];
  bit          pm_active [32];
  logic [5:0]  pm_clip [32];
  logic [16:0] pm_pos [32];
  logic [15:0] pm_gain [32];
  bit          pm_loops [32];
  logic [15:0] pm_master = mvam_pkg::UNITY_GAIN;

  mix_res_t    frames_due [$];
  int          err_count = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  multi_voice_audio_mixer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", field, got, want);
    err_count++;
  endtask

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one operation on the predictor state, gives the result the block must return
  function automatic mix_res_t mix_predict(mix_item_t it);
    mix_res_t   r;
    int         accl, accr, g, mg, s;
    logic [5:0] c;
    logic [31:0] frame;
    logic [15:0] a;
    r = '0;
    accl = 0;
    accr = 0;
    case (it.mode)
      mvam_pkg::MODE_WRITE: pm_samples[it.addr] = {it.rsmp, it.lsmp};
      mvam_pkg::MODE_DEFINE: begin
        pm_clip_start[it.cid] = it.addr;
        pm_clip_len[it.cid] = it.len;
      end
      mvam_pkg::MODE_PLAY: begin
        if (pm_clip_len[it.cid] != 0) begin
          for (int v = 0; v < 32; v++) begin
            if (!pm_active[v]) begin
              pm_active[v] = 1'b1;
              pm_clip[v] = it.cid;
              pm_pos[v] = '0;
              pm_gain[v] = (it.vol > mvam_pkg::UNITY_GAIN) ? mvam_pkg::UNITY_GAIN : it.vol;
              pm_loops[v] = it.lp;
              r.started = 1'b1;
              break;
            end
          end
        end
      end
      mvam_pkg::MODE_STOP: begin
        for (int v = 0; v < 32; v++)
          if (pm_clip[v] == it.cid) begin
            pm_active[v] = 1'b0;
            pm_pos[v] = '0;
          end
      end
      mvam_pkg::MODE_ALL: begin
        for (int v = 0; v < 32; v++) begin
          pm_active[v] = 1'b0;
          pm_pos[v] = '0;
        end
      end
      mvam_pkg::MODE_TICK: begin
        mg = (pm_master > mvam_pkg::UNITY_GAIN) ? 32768 : int'(pm_master);
        for (int v = 0; v < 32; v++) begin
          if (!pm_active[v]) continue;
          c = pm_clip[v];
          if (pm_clip_len[c] == 0) continue;
          if (pm_pos[v] >= pm_clip_len[c]) begin
            if (pm_loops[v]) pm_pos[v] = '0;
            else begin
              pm_active[v] = 1'b0;
              continue;
            end
          end
          g = (int'(pm_gain[v]) * mg) >>> 15;
          a = pm_clip_start[c] + pm_pos[v][15:0];
          frame = pm_samples.exists(a) ? pm_samples[a] : 32'h0;
          s = int'($signed(frame[15:0]));
          accl = sat16(accl + ((s * g) >>> 15));
          s = int'($signed(frame[31:16]));
          accr = sat16(accr + ((s * g) >>> 15));
          pm_pos[v] = pm_pos[v] + 17'd1;
        end
      end
      default: ;
    endcase
    for (int v = 0; v < 32; v++)
      if (pm_active[v]) begin
        r.count++;
        if (pm_clip[v] == it.cid) r.playing = 1'b1;
      end
    r.left = accl[15:0];
    r.right = accr[15:0];
    return r;
  endfunction

  // offer one item, wait for its transfer, record what must come back
  task automatic send_op(mix_item_t it, bit typed = 1'b0, mix_res_t want = '0);
    mix_res_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {it.lp, it.vol, it.len, it.rsmp, it.lsmp, it.cid, it.addr};
    do @(posedge clk); while (!s_tready);
    r = mix_predict(it);
    frames_due.insert(frames_due.size(), typed ? want : r);
  endtask

  // wait until the block is empty, then write the master gain
  task automatic set_master(logic [15:0] value);
    s_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pm_master = value;
  endtask

  function automatic mix_item_t random_op();
    mix_item_t it;
    int        k, o;
    it = '{3'($urandom_range(0, 7)), 16'($urandom), 6'($urandom), 16'($urandom),
           16'($urandom), 17'($urandom_range(0, 131071)), 16'($urandom),
           1'($urandom_range(0, 1))};
    k = $urandom_range(0, 99);
    if (k < 30) it.mode = mvam_pkg::MODE_TICK;
    else if (k < 45) begin
      it.mode = mvam_pkg::MODE_WRITE;
      if ($urandom_range(0, 1)) it.addr = SAFE_BASE + 16'($urandom_range(0, SAFE_SPAN - 1));
    end else if (k < 60) begin
      it.mode = mvam_pkg::MODE_DEFINE;
      if ($urandom_range(0, 4) == 0) begin
        it.cid = 6'($urandom_range(WILD_CLIP, 63));
        it.len = 17'($urandom_range(0, 65536));
      end else begin
        it.cid = 6'($urandom_range(0, 7));
        o = $urandom_range(0, SAFE_SPAN - 1);
        it.addr = SAFE_BASE + 16'(o);
        it.len = ($urandom_range(0, 9) == 0) ? 17'd0 : 17'($urandom_range(1, SAFE_SPAN - o));
      end
    end else if (k < 88) begin
      it.mode = mvam_pkg::MODE_PLAY;
      it.cid = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, WILD_CLIP - 1)
                                               : $urandom_range(0, 7));
      if ($urandom_range(0, 1)) it.vol = 16'($urandom_range(0, 32768));
    end else if (k < 94) begin
      it.mode = mvam_pkg::MODE_STOP;
      if ($urandom_range(0, 1)) it.cid = 6'($urandom_range(0, 7));
    end else if (k < 97) it.mode = mvam_pkg::MODE_ALL;
    else it.mode = (k == 97) ? MODE_SPARE_A : MODE_SPARE_B;
    return it;
  endfunction

  // result side: check each transfer, stall in bursts, one long hold-off
  initial begin
    int       burst = 0;
    int       hold = 0;
    mix_res_t got, want;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (frames_due.size() == 0) begin
          $display("unexpected result transfer");
          err_count++;
        end else begin
          want = frames_due.pop_front();
          if (got.left !== want.left)
            report_mismatch("left_out", $signed(got.left), $signed(want.left));
          if (got.right !== want.right)
            report_mismatch("right_out", $signed(got.right), $signed(want.right));
          if (got.started !== want.started)
            report_mismatch("voice_started", got.started, want.started);
          if (got.playing !== want.playing)
            report_mismatch("clip_playing", got.playing, want.playing);
          if (got.count !== want.count)
            report_mismatch("active_voices", got.count, want.count);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 300;
        m_tready <= 1'b0;
      end else if (hold > 0) hold--;
      else if (!idle_on) m_tready <= 1'b1;
      else if (burst > 0) burst--;
      else begin
        m_tready <= 1'($urandom_range(0, 1));
        burst = $urandom_range(1, 15);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows [$];
    rows = '{
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 1, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h8000, 1'b1}, 1, '0},
      '{'{MODE_SPARE_A, 16'hFFFF, 6'd63, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 1'b1},
        1, '0},
      '{'{MODE_SPARE_B, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 1, '0},
      '{'{mvam_pkg::MODE_WRITE, 16'h0000, 6'd0, 16'h7FFF, 16'h8000, 17'd0, 16'h0, 1'b0},
        0, '0},
      '{'{mvam_pkg::MODE_WRITE, 16'h0001, 6'd0, 16'h8000, 16'h7FFF, 17'd0, 16'h0, 1'b0},
        0, '0},
      '{'{mvam_pkg::MODE_WRITE, 16'hFFFF, 6'd0, 16'h7FFF, 16'h7FFF, 17'd0, 16'h0, 1'b0},
        0, '0},
      '{'{mvam_pkg::MODE_WRITE, 16'hFFFE, 6'd0, 16'h8000, 16'h8000, 17'd0, 16'h0, 1'b0},
        0, '0},
      '{'{mvam_pkg::MODE_DEFINE, 16'h0000, 6'd0, 16'h0, 16'h0, 17'd2, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_DEFINE, 16'hFFFE, 6'd1, 16'h0, 16'h0, 17'd4, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_DEFINE, 16'hFFFF, 6'd63, 16'h0, 16'h0, 17'd65536, 16'h0, 1'b0},
        0, '0},
      '{'{mvam_pkg::MODE_DEFINE, 16'h0000, 6'd2, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd2, 16'h0, 16'h0, 17'd0, 16'h8000, 1'b1}, 0, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h8000, 1'b1}, 0, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h8000, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd1, 16'h0, 16'h0, 17'd0, 16'hFFFF, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd1, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      // shrink a clip under a playing voice
      '{'{mvam_pkg::MODE_DEFINE, 16'hFFFE, 6'd1, 16'h0, 16'h0, 17'd1, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd1, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_PLAY, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0000, 1'b1}, 0, '0},
      '{'{mvam_pkg::MODE_STOP, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_TICK, 16'h0, 6'd1, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 0, '0},
      '{'{mvam_pkg::MODE_ALL, 16'h0, 6'd0, 16'h0, 16'h0, 17'd0, 16'h0, 1'b0}, 1, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset gain
    foreach (rows[i]) send_op(rows[i].it, rows[i].typed, rows[i].want);

    // fill the region that playable clips read from
    for (int a = 0; a < SAFE_SPAN; a++)
      send_op('{mvam_pkg::MODE_WRITE, SAFE_BASE + 16'(a), 6'($urandom), 16'($urandom),
                16'($urandom), 17'($urandom_range(0, 131071)), 16'($urandom),
                1'($urandom_range(0, 1))});

    // random phases over several master gains, long receiver hold early on
    for (int n = 0; n < 100; n++) begin
      if (n == 20) hold_req = 1'b1;
      send_op(random_op());
    end
    set_master(16'h0000);
    for (int n = 0; n < 50; n++) send_op(random_op());
    set_master(16'hFFFF);
    for (int n = 0; n < 50; n++) send_op(random_op());
    set_master(16'h4000);
    for (int n = 0; n < 50; n++) send_op(random_op());
    set_master(16'h8000);
    for (int n = 0; n < 30; n++) send_op(random_op());
    set_master(16'($urandom_range(1, 32767)));
    idle_on = 1'b0;
    for (int n = 0; n < 40; n++) send_op(random_op());
    s_tvalid <= 1'b0;

    // drain
    while (frames_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mvam_pkg.sv
hw/rtl/mvam_ctrl.sv
hw/rtl/mvam_datapath.sv
hw/rtl/multi_voice_audio_mixer.sv
hw/rtl/mvam_checker.sv
dv/tb_multi_voice_audio_mixer.sv
